// ----- hdl/bchd_pkg.sv -----
// Shared types and constants for the button click and hold detector.
package bchd_pkg;

  localparam int unsigned TICK_W     = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned INTERVAL_W = 10;
  localparam int unsigned DEBOUNCE_W = 8;
  localparam int unsigned CLICKS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(60000);

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(10);
  localparam logic [COUNT_W-1:0]    HOLD_RST     = COUNT_W'(50);
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(2);
  localparam logic [COUNT_W-1:0]    GAP_RST      = COUNT_W'(30);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIODS       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_PERIODS   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP_PERIODS = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_HOLD   = 2'd3
  } event_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_ms;
    logic              pin_level;
  } in_item_t;

  typedef struct packed {
    event_t event_res;
    logic   updated;
  } out_item_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] update_interval;
    logic [COUNT_W-1:0]    hold_periods;
    logic [DEBOUNCE_W-1:0] debounce_periods;
    logic [COUNT_W-1:0]    double_gap_periods;
  } cfg_t;

endpackage

// ----- hdl/button_click_hold_detector_top.sv -----
// Top level of the button click and hold detector.
//
// Input channel: in_valid / in_stall / in_item carry one transaction per
// sample, holding a free-running millisecond tick and the raw active-low
// button level. Output channel: out_valid / out_stall / out_item return one
// transaction per input: the event code (none, single, double, hold) and a
// flag telling whether that sample passed the update interval.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data write one of
// four registers (update interval, hold target, debounce, double-click gap);
// cfg_ready is always high. Write only while no transaction is in flight.
// From input to output an item passes the input register, then the detector
// state update and a result register. Throughput is one transaction per
// cycle while the receiver does not stall. Reset clears the pipeline valids
// and the detector state and restores the register defaults. When the
// receiver stalls, the result register holds, the input register fills and
// then in_stall rises; nothing is dropped.
module button_click_hold_detector_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bchd_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bchd_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bchd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bchd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bchd_pkg::*;

  cfg_t      cfg;
  in_item_t  item;
  logic      item_valid;
  logic      step;
  out_item_t result;

  bchd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance the held item into the result register when that register is
  // empty or being drained this cycle.
  assign step     = item_valid && (!out_valid || !out_stall);
  // Accept a new item whenever the input register empties or is already empty.
  assign in_stall = item_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

  bchd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // Hold the result while the receiver stalls; drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result lost");

  a_step_only_held: assert property (@(posedge clk) disable iff (rst)
    step |-> item_valid)
    else $error("core stepped without an item");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("stepped item produced no result");

endmodule

// ----- hdl/bchd_cfg.sv -----
// Configuration register file for the button click and hold detector.
module bchd_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bchd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bchd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output bchd_pkg::cfg_t                    cfg
);
  import bchd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.update_interval    <= INTERVAL_RST;
      cfg.hold_periods       <= HOLD_RST;
      cfg.debounce_periods   <= DEBOUNCE_RST;
      cfg.double_gap_periods <= GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      // take the low bits of each register; unknown indexes are dropped
      unique case (cfg_index)
        REG_UPDATE_INTERVAL:    cfg.update_interval    <= cfg_data[INTERVAL_W-1:0];
        REG_HOLD_PERIODS:       cfg.hold_periods       <= cfg_data[COUNT_W-1:0];
        REG_DEBOUNCE_PERIODS:   cfg.debounce_periods   <= cfg_data[DEBOUNCE_W-1:0];
        REG_DOUBLE_GAP_PERIODS: cfg.double_gap_periods <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/bchd_core.sv -----
// Detector state and single-pass update logic for one tick item.
module bchd_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  bchd_pkg::in_item_t  item,
  input  bchd_pkg::cfg_t      cfg,
  output bchd_pkg::out_item_t result
);
  import bchd_pkg::*;

  logic [TICK_W-1:0]   prev_tick;
  logic [COUNT_W-1:0]  press_periods;
  logic [COUNT_W-1:0]  release_periods;
  logic [CLICKS_W-1:0] clicks;

  logic [COUNT_W-1:0]  press_periods_next;
  logic [COUNT_W-1:0]  release_periods_next;
  logic [CLICKS_W-1:0] clicks_next;

  logic [TICK_W-1:0]   advance;
  logic                upd;
  logic                pressed;
  logic [COUNT_W-1:0]  press_inc;
  logic [COUNT_W-1:0]  release_inc;
  logic [CLICKS_W-1:0] clicks_mid;
  event_t              ev;

  assign advance = item.tick_ms - prev_tick;
  assign upd     = advance >= {{(TICK_W-INTERVAL_W){1'b0}}, cfg.update_interval};
  assign pressed = ~item.pin_level;

  assign press_inc   = (press_periods < COUNT_SAT) ? press_periods + 1'b1 : press_periods;
  assign release_inc = (release_periods < COUNT_SAT) ? release_periods + 1'b1
                                                     : release_periods;

  always_comb begin
    press_periods_next   = press_periods;
    release_periods_next = release_periods;
    clicks_next          = clicks;
    clicks_mid           = clicks;
    ev                   = EV_NONE;
    if (pressed) begin
      release_periods_next = '0;
      press_periods_next   = press_inc;
      if (press_inc == cfg.hold_periods) begin
        ev          = EV_HOLD;
        clicks_next = '0;
      end
    end else begin
      // a finished press counts as a click only between debounce and hold
      if (press_periods != '0) begin
        if (press_periods > {{(COUNT_W-DEBOUNCE_W){1'b0}}, cfg.debounce_periods} &&
            press_periods < cfg.hold_periods) begin
          clicks_mid = clicks + 1'b1;
        end
        press_periods_next = '0;
      end
      clicks_next = clicks_mid;
      if (clicks_mid != '0) begin
        release_periods_next = release_inc;
        if (clicks_mid == CLICKS_W'(2)) begin
          ev                   = EV_DOUBLE;
          clicks_next          = '0;
          release_periods_next = '0;
        end else if (release_inc > cfg.double_gap_periods) begin
          if (clicks_mid == CLICKS_W'(1)) begin
            ev = EV_SINGLE;
          end
          clicks_next          = '0;
          release_periods_next = '0;
        end
      end else begin
        release_periods_next = '0;
      end
    end
  end

  assign result.event_res = upd ? ev : EV_NONE;
  assign result.updated   = upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_tick       <= '0;
      press_periods   <= '0;
      release_periods <= '0;
      clicks          <= '0;
    end else if (step && upd) begin
      prev_tick       <= item.tick_ms;
      press_periods   <= press_periods_next;
      release_periods <= release_periods_next;
      clicks          <= clicks_next;
    end
  end

  a_clicks_low: assert property (@(posedge clk) disable iff (rst)
    clicks == '0 || clicks == CLICKS_W'(1))
    else $error("click count left above one");

  a_press_sat: assert property (@(posedge clk) disable iff (rst)
    press_periods <= COUNT_SAT)
    else $error("press counter beyond saturation");

  a_release_needs_click: assert property (@(posedge clk) disable iff (rst)
    release_periods != '0 |-> clicks == CLICKS_W'(1))
    else $error("release counting without a pending click");

  a_tick_capture: assert property (@(posedge clk) disable iff (rst)
    step && upd |=> prev_tick == $past(item.tick_ms))
    else $error("update tick not captured");

endmodule

// ----- bench/bchd_event_checker.sv -----
// Watches the detector's channels, predicts each result and compares it with the block's output.
module bchd_event_checker
  import bchd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  logic [INTERVAL_W-1:0] interval_q;
  logic [COUNT_W-1:0]    hold_q;
  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [COUNT_W-1:0]    gap_q;

  logic [TICK_W-1:0]     last_tick;
  logic [COUNT_W-1:0]    press_cnt;
  logic [COUNT_W-1:0]    release_cnt;
  logic [CLICKS_W-1:0]   click_cnt;

  out_item_t pending_events[$];

  // Advance the detector state by one sample and return the event it raises.
  function automatic out_item_t detect_step(in_item_t it);
    out_item_t         res;
    logic [TICK_W-1:0] delta;
    res.event_res = EV_NONE;
    res.updated   = 1'b0;
    delta = it.tick_ms - last_tick;
    if (delta < TICK_W'(interval_q)) return res;
    last_tick   = it.tick_ms;
    res.updated = 1'b1;
    if (!it.pin_level) begin
      release_cnt = '0;
      if (press_cnt < COUNT_SAT) press_cnt = press_cnt + 1'b1;
      if (press_cnt == hold_q) begin
        res.event_res = EV_HOLD;
        click_cnt     = '0;
      end
    end else begin
      if (press_cnt != '0) begin
        if (press_cnt > COUNT_W'(debounce_q) && press_cnt < hold_q)
          click_cnt = click_cnt + 1'b1;
        press_cnt = '0;
      end
      if (click_cnt != '0) begin
        if (release_cnt < COUNT_SAT) release_cnt = release_cnt + 1'b1;
        if (click_cnt == CLICKS_W'(2)) begin
          res.event_res = EV_DOUBLE;
          click_cnt     = '0;
          release_cnt   = '0;
        end else if (release_cnt > gap_q) begin
          if (click_cnt == CLICKS_W'(1)) res.event_res = EV_SINGLE;
          click_cnt   = '0;
          release_cnt = '0;
        end
      end else begin
        release_cnt = '0;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_res;
    int        errs;
    errs = 0;
    if (rst) begin
      interval_q  = INTERVAL_RST;
      hold_q      = HOLD_RST;
      debounce_q  = DEBOUNCE_RST;
      gap_q       = GAP_RST;
      last_tick   = '0;
      press_cnt   = '0;
      release_cnt = '0;
      click_cnt   = '0;
      pending_events.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_UPDATE_INTERVAL:    interval_q = cfg_data[INTERVAL_W-1:0];
          REG_HOLD_PERIODS:       hold_q     = cfg_data[COUNT_W-1:0];
          REG_DEBOUNCE_PERIODS:   debounce_q = cfg_data[DEBOUNCE_W-1:0];
          REG_DOUBLE_GAP_PERIODS: gap_q      = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) pending_events.push_back(detect_step(in_item));
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual event_res=%0d updated=%0b",
                   $time, out_item.event_res, out_item.updated);
          errs++;
        end else begin
          exp_res = pending_events.pop_front();
          if (out_item.event_res !== exp_res.event_res) begin
            $display("%0t: event_res mismatch: expected %0d, actual %0d",
                     $time, exp_res.event_res, out_item.event_res);
            errs++;
          end
          if (out_item.updated !== exp_res.updated) begin
            $display("%0t: updated mismatch: expected %0b, actual %0b",
                     $time, exp_res.updated, out_item.updated);
            errs++;
          end
        end
      end
      mismatches  <= mismatches + errs;
      outstanding <= pending_events.size();
    end
  end

endmodule

// ----- bench/button_click_hold_detector_top_test.sv -----
// Stimulus and verdict for the button click and hold detector, checked by bchd_event_checker.
module button_click_hold_detector_top_test;
  import bchd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches;
  int outstanding;
  int idle_cycles;

  // Idling knobs, in percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Stimulus-side view of the settings, used only to shape gestures
  logic [INTERVAL_W-1:0] cur_interval = INTERVAL_RST;
  int                    cur_hold     = int'(HOLD_RST);
  int                    cur_deb      = int'(DEBOUNCE_RST);
  int                    cur_gap      = int'(GAP_RST);
  logic [TICK_W-1:0]     last_upd     = '0;
  int                    items_sent   = 0;

  button_click_hold_detector_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bchd_event_checker events_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: stall at random in the share of cycles the current phase asks for.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog: end the run once no transaction of any kind has moved for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no transaction for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one sample and hold it until the block takes it. Valid stays high
  // after the transaction so a back-to-back sample needs no extra edge.
  task automatic send_item(input in_item_t it);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Send one sample and track where the block's last update landed.
  task automatic emit(input logic [TICK_W-1:0] tick, input logic pin);
    in_item_t it;
    it.tick_ms   = tick;
    it.pin_level = pin;
    send_item(it);
    if (tick - last_upd >= TICK_W'(cur_interval)) last_upd = tick;
    items_sent++;
  endtask

  // One update period at the given level, sometimes preceded by a sample
  // that falls short of the interval and must be ignored.
  task automatic period(input logic pin);
    int                iv;
    logic [TICK_W-1:0] tick;
    iv = int'(cur_interval);
    if (iv != 0 && $urandom_range(0, 4) == 0)
      emit(last_upd + $urandom_range(0, iv - 1), 1'($urandom_range(0, 1)));
    tick = last_upd + iv;
    if ($urandom_range(0, 3) == 0) tick = tick + $urandom_range(0, iv);
    emit(tick, pin);
  endtask

  task automatic press_for(input int n);
    repeat (n) period(1'b0);
  endtask

  task automatic release_for(input int n);
    repeat (n) period(1'b1);
  endtask

  // Hold until every expected result is back, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all four registers plus one write to an unused index, which the
  // block must drop.
  task automatic set_config(input logic [CFG_DATA_W-1:0] iv_data,
                            input logic [CFG_DATA_W-1:0] hold_data,
                            input logic [CFG_DATA_W-1:0] deb_data,
                            input logic [CFG_DATA_W-1:0] gap_data);
    write_reg(REG_UPDATE_INTERVAL, iv_data);
    write_reg(REG_HOLD_PERIODS, hold_data);
    write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
    write_reg(REG_DEBOUNCE_PERIODS, deb_data);
    write_reg(REG_DOUBLE_GAP_PERIODS, gap_data);
    cfg_valid <= 1'b0;
    cur_interval = iv_data[INTERVAL_W-1:0];
    cur_hold     = int'(hold_data);
    cur_deb      = int'(deb_data[DEBOUNCE_W-1:0]);
    cur_gap      = int'(gap_data);
    @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default: begin send_idle_pct = 17; recv_stall_pct = 17; end
    endcase
  endtask

  // Mostly well-formed gestures with random lengths, mixed with short taps,
  // off-interval noise and arbitrary tick jumps.
  task automatic run_gestures(input int budget);
    int start;
    int gap_len;
    start = items_sent;
    while (items_sent - start < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          press_for($urandom_range(cur_deb + 1, cur_hold - 1));
          release_for($urandom_range(1, 3));
        end
        3, 4: begin
          gap_len = (cur_gap > 0) ? $urandom_range(1, cur_gap) : 1;
          press_for($urandom_range(cur_deb + 1, cur_hold - 1));
          release_for(gap_len);
          press_for($urandom_range(cur_deb + 1, cur_hold - 1));
          release_for(1);
        end
        5: begin
          press_for(cur_hold + $urandom_range(0, 4));
          release_for(1);
        end
        6: begin
          press_for((cur_deb > 0) ? $urandom_range(1, cur_deb) : 1);
          release_for(1);
        end
        7: release_for($urandom_range(1, cur_gap + 4));
        8: begin
          repeat ($urandom_range(1, 4))
            emit(last_upd + $urandom_range(0, 2 * cur_interval), 1'($urandom_range(0, 1)));
        end
        default: emit(TICK_W'($urandom), 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  initial begin
    int deb;
    int hold;
    int gap;
    int iv;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every event kind, a sample short of the interval, tick wrap
    // and a tap too short to count.
    set_config(16'd5, 16'd4, 16'd1, 16'd1);
    emit(32'd3, 1'b0);
    emit(32'hFFFF_FFFF, 1'b1);
    emit(32'd8, 1'b0);
    press_for(1);
    release_for(2);
    press_for(2);
    release_for(1);
    press_for(2);
    release_for(1);
    press_for(5);
    release_for(1);
    press_for(1);
    release_for(1);

    // Zero interval, hold and debounce with junk in the upper data bits:
    // equal ticks still update and no press ever counts.
    drain();
    set_config(16'hFC00, 16'd0, 16'h5500, 16'd0);
    emit(last_upd, 1'b0);
    emit(last_upd, 1'b0);
    emit(last_upd, 1'b1);
    emit(last_upd, 1'b1);

    // An interval of 1000 and the largest debounce, with a wrap across zero.
    drain();
    set_config(16'hFFE8, 16'd3, 16'hFFFF, 16'd0);
    emit(last_upd + 32'd999, 1'b0);
    press_for(3);
    emit(32'hFFFF_FC00, 1'b1);
    emit(32'h0000_0100, 1'b0);
    release_for(1);

    // Random phases: fresh settings each time, idling cycled through all modes.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      deb  = $urandom_range(0, 3);
      hold = $urandom_range(deb + 2, 24);
      gap  = $urandom_range(0, 12);
      iv   = (ph == 5) ? $urandom_range(1, 1000) : $urandom_range(1, 20);
      set_config({6'($urandom), 10'(iv)}, CFG_DATA_W'(hold), {8'($urandom), 8'(deb)},
                 CFG_DATA_W'(gap));
      set_idling(ph % 4);
      run_gestures(160);
    end

    // Widest gap: a lone click never times out and waits for a second
    // click, which then raises a double click.
    drain();
    set_idling(0);
    set_config(16'd1, 16'd1000, 16'h0000, 16'hFFFF);
    press_for(3);
    release_for(100);
    press_for(3);
    release_for(2);

    drain();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bchd_pkg.sv
hdl/bchd_cfg.sv
hdl/bchd_core.sv
hdl/button_click_hold_detector_top.sv
bench/bchd_event_checker.sv
bench/button_click_hold_detector_top_test.sv
